// ===== rtl/set_assoc_tag_store_lru_unit_macros.svh =====
// Assertion macros for the set-associative tag store.
`ifndef SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH
`define SET_ASSOC_TAG_STORE_LRU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SATSLRU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("satslru same-cycle check failed");
`define SATSLRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("satslru next-cycle check failed");
`else
`define SATSLRU_ASSERT_SAME(lbl, ante, cons)
`define SATSLRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/satslru_pkg.sv =====
// Shared types and constants for the set-associative tag store.
`default_nettype none
package satslru_pkg;
	localparam int unsigned CTR_THRESH = 3;
	localparam int unsigned VTAG_W = 18;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 32;

	typedef enum logic [2:0] {
		OP_TOUCH = 3'd0,
		OP_FILL  = 3'd1,
		OP_QUERY = 3'd2,
		OP_SET   = 3'd3,
		OP_UP    = 3'd4,
		OP_DOWN  = 3'd5
	} op_t;

	localparam logic [2:0] ST_INVALID    = 3'd0;
	localparam logic [2:0] ST_MODIFIED   = 3'd1;
	localparam logic [2:0] ST_SHMODIFIED = 3'd3;

	typedef enum logic [1:0] {
		FSM_CLEAR = 2'd0,
		FSM_IDLE  = 2'd1,
		FSM_MOD   = 2'd2,
		FSM_EVAL  = 2'd3
	} fsm_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic mod_step;
		logic rd_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mod_done;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/satslru_ctrl.sv =====
// Controller state machine for the set-associative tag store.
`default_nettype none
module satslru_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire satslru_pkg::sts_t sts,
	output satslru_pkg::cmd_t      cmd
);
	import satslru_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (sts.clear_last) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (s_tvalid) state_d = FSM_MOD;
			end
			FSM_MOD: begin
				if (sts.mod_done) state_d = FSM_EVAL;
			end
			FSM_EVAL: begin
				if (!sts.out_busy) state_d = FSM_IDLE;
			end
			default: state_d = FSM_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			FSM_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			FSM_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
			end
			FSM_MOD: begin
				cmd.mod_step = !sts.mod_done;
				cmd.rd_en = sts.mod_done;
			end
			FSM_EVAL: begin
				cmd.commit = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/satslru_dp.sv =====
// Datapath for the set-associative tag store: set memory, index unit, update logic.
`default_nettype none
module satslru_dp #(
	parameter int unsigned WAYS = 8,
	parameter int unsigned SETS = 256,
	parameter int unsigned OFFSET_BITS = 6,
	parameter int unsigned ADDR_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [satslru_pkg::S_DATA_W-1:0]     s_tdata,
	input  wire logic                                 m_tready,
	output logic                                      m_tvalid,
	output logic [satslru_pkg::M_DATA_W-1:0]          m_tdata,
	input  wire satslru_pkg::cmd_t                    cmd,
	output satslru_pkg::sts_t                         sts
);
	import satslru_pkg::*;

	localparam int unsigned AE = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam logic [63:0] AMASK = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
	localparam int unsigned SB = $clog2(SETS + 1) - 1;
	localparam int unsigned IW = $clog2(SETS);
	localparam bit POW2 = ((SETS & (SETS - 1)) == 0);
	localparam int unsigned LN_W = AE - OFFSET_BITS;
	// line number width, at least as wide as the set index
	localparam int unsigned LX = (LN_W > IW) ? LN_W : IW;
	// reciprocal of SETS, exact for every line number below 2**LX
	localparam int unsigned SH = LX + IW;
	localparam int unsigned PW = 2 * LX + 1;
	localparam int unsigned QW = LX + 1 - IW;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SETS) - 64'd1) / 64'(SETS);
	localparam logic [IW-1:0] SETS_LO = IW'(SETS);
	localparam logic [1:0] RED_STEPS = POW2 ? 2'd0 : 2'd2;
	localparam int TAG_RAW = int'(AE) - int'(OFFSET_BITS) - int'(SB);
	localparam int unsigned TAG_W = (TAG_RAW < 1) ? 1 : TAG_RAW;
	localparam int unsigned RW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [2:0]       st;
		logic [RW-1:0]    rk;
		logic [7:0]       ct;
	} way_t;
	typedef way_t [WAYS-1:0] row_t;

	row_t             mem_q [SETS];
	row_t             rd_row_q;
	row_t             new_row;
	row_t             rst_row;
	logic [IW-1:0]    clr_q;
	logic [LX-1:0]    ln_q;
	logic [IW-1:0]    rem_q;
	logic [1:0]       cnt_q;
	logic [PW-1:0]    prod_q;
	logic [QW-1:0]    quo;
	logic [TAG_W-1:0] tag_q;
	op_t              op_q;
	logic [2:0]       nst_q;
	logic [IW-1:0]    set_sel;
	logic [63:0]      a64;
	logic             m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign a64 = {32'd0, s_tdata[34:3]} & AMASK;
	assign quo = prod_q[PW-1 -: QW];
	assign set_sel = POW2 ? ln_q[IW-1:0] : rem_q;

	assign sts.clear_last = (clr_q == IW'(SETS - 1));
	assign sts.mod_done = (cnt_q == '0);
	assign sts.out_busy = m_tvalid_q && !m_tready;

	// request capture; set index = line number minus quotient times SETS
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ln_q <= LX'(a64 >> OFFSET_BITS);
			rem_q <= '0;
			tag_q <= TAG_W'(a64 >> (OFFSET_BITS + SB));
			op_q <= op_t'(s_tdata[2:0]);
			nst_q <= s_tdata[37:35];
		end else if (cmd.mod_step) begin
			if (cnt_q[1]) prod_q <= PW'(ln_q) * PW'(RECIP[LX:0]);
			else rem_q <= ln_q[IW-1:0] - IW'(quo * SETS_LO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.accept) cnt_q <= RED_STEPS;
			else if (cmd.mod_step) cnt_q <= cnt_q - 1'b1;
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.commit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rst_row[w].tag = '0;
			rst_row[w].st = ST_INVALID;
			rst_row[w].rk = RW'(w);
			rst_row[w].ct = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) mem_q[clr_q] <= rst_row;
		else if (cmd.commit) mem_q[set_sel] <= new_row;
		if (cmd.rd_en) rd_row_q <= mem_q[set_sel];
	end

	logic          hit;
	logic [WW-1:0] hit_way;
	logic          inv_any;
	logic [WW-1:0] inv_way;
	logic [WW-1:0] lru_way;
	logic [WW-1:0] vic_way;
	logic [WW-1:0] mr_way;
	logic          mr_en;
	logic          wb;
	logic [RW-1:0] old_rk;
	logic [2:0]    out_st;
	logic [7:0]    out_ct;
	logic [63:0]   vtag_ext;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		inv_any = 1'b0;
		inv_way = '0;
		lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row_q[w].tag == tag_q) begin
				hit = 1'b1;
				hit_way = WW'(w);
			end
			if (rd_row_q[w].st == ST_INVALID) begin
				inv_any = 1'b1;
				inv_way = WW'(w);
			end
			if (rd_row_q[w].rk == RW'(WAYS - 1)) lru_way = WW'(w);
		end
	end

	always_comb begin
		vic_way = inv_any ? inv_way : lru_way;
		wb = (op_q == OP_FILL) && !inv_any && (rd_row_q[vic_way].st >= ST_MODIFIED)
			&& (rd_row_q[vic_way].st <= ST_SHMODIFIED);
		new_row = rd_row_q;
		mr_en = 1'b0;
		mr_way = hit_way;
		case (op_q)
			OP_TOUCH: begin
				mr_en = hit;
			end
			OP_FILL: begin
				mr_en = 1'b1;
				mr_way = vic_way;
				new_row[vic_way].tag = tag_q;
				new_row[vic_way].st = nst_q;
				new_row[vic_way].ct = 8'(CTR_THRESH);
			end
			OP_SET: begin
				if (hit) new_row[hit_way].st = nst_q;
			end
			OP_UP: begin
				if (hit && rd_row_q[hit_way].ct != 8'hFF)
					new_row[hit_way].ct = rd_row_q[hit_way].ct + 8'd1;
			end
			OP_DOWN: begin
				if (hit && rd_row_q[hit_way].ct != 8'h00)
					new_row[hit_way].ct = rd_row_q[hit_way].ct - 8'd1;
			end
			default: begin
				mr_en = 1'b0;
			end
		endcase
		old_rk = rd_row_q[mr_way].rk;
		if (mr_en) begin
			for (int w = 0; w < WAYS; w++) begin
				if (rd_row_q[w].rk < old_rk) new_row[w].rk = rd_row_q[w].rk + 1'b1;
			end
			new_row[mr_way].rk = '0;
		end
	end

	always_comb begin
		out_st = hit ? rd_row_q[hit_way].st : ST_INVALID;
		out_ct = hit ? rd_row_q[hit_way].ct : 8'd0;
		vtag_ext = wb ? 64'(rd_row_q[vic_way].tag) : 64'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= {1'b0, vtag_ext[VTAG_W-1:0], wb, out_ct, out_st, hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule
`default_nettype wire

// ===== rtl/set_assoc_tag_store_lru_unit.sv =====
// Top level of the set-associative tag store with true LRU replacement.
// Set-associative tag store with coherence states, true LRU and an 8-bit
// saturating counter per line. Each request reads one whole set row from a
// single-port set memory, compares all ways in parallel, and writes the
// updated row back. A request passes through accept, set read, and evaluate
// and write back when SETS is a power of two; otherwise the set index is
// first reduced modulo SETS by a reciprocal multiply followed by a
// multiply-subtract, before the set read. The result sits in an output
// register; the next request is accepted while it waits, and its write back
// stalls until that result is taken. After reset a clearing pass over all
// SETS rows initializes the memory (tags and counters zero, all lines
// Invalid, recency rank equal to way number); s_tready stays low during it.
// Only one request is in flight at a time.
`default_nettype none
module set_assoc_tag_store_lru_unit #(
	parameter int unsigned WAYS = 8,
	parameter int unsigned SETS = 256,
	parameter int unsigned OFFSET_BITS = 6,
	parameter int unsigned ADDR_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// req_type[2:0], address[34:3], new_state[37:35], zero[39:38]
	input  wire logic [satslru_pkg::S_DATA_W-1:0] s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// hit[0], line_state[3:1], line_count[11:4], writeback[12],
	// victim_tag[30:13], zero[31]
	output logic [satslru_pkg::M_DATA_W-1:0]      m_tdata
);
	import satslru_pkg::*;
	`include "set_assoc_tag_store_lru_unit_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// sequencing: clear sweep, idle, index reduction, evaluate and write back
	satslru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// set memory, tag compare, victim pick, LRU update, result register
	satslru_dp #(
		.WAYS        (WAYS),
		.SETS        (SETS),
		.OFFSET_BITS (OFFSET_BITS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// a request in flight blocks the next one
	`SATSLRU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a committed result is presented in the next cycle
	`SATSLRU_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid)
	// index reduction never overlaps intake or commit
	`SATSLRU_ASSERT_SAME(a_step_excl, cmd.mod_step, !s_tready && !cmd.commit)
endmodule
`default_nettype wire
